// ===== rtl/lz4d_pkg.sv =====
// Package for the LZ4 block decoder: payload structs, phase and status codes.
// No dependencies.
package lz4d_pkg;

    localparam int LENGTH_BITS   = 24;
    localparam int HISTORY_DEPTH = 65536;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int LIT_W         = LENGTH_BITS + 1;
    localparam logic [LENGTH_BITS-1:0] LIMIT_RESET = LENGTH_BITS'(65536);
    localparam logic [LIT_W-1:0] LIT_SAT = {LIT_W{1'b1}};

    typedef enum logic [2:0] {
        PH_TOKEN, PH_LIT_EXT, PH_LITERALS, PH_OFF_LO, PH_OFF_HI, PH_MATCH_EXT
    } phase_t;

    typedef enum logic [2:0] {
        ST_DATA = 3'd0, ST_DONE = 3'd1, ST_IN_OVER = 3'd2,
        ST_OUT_OVER = 3'd3, ST_BAD_OFFSET = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       block_end;
    } in_item_t;

    typedef struct packed {
        logic [63:0]            data_word;
        logic [3:0]             byte_count;
        logic                   run_last;
        logic [2:0]             status;
        logic [LENGTH_BITS-1:0] decoded_length;
    } out_item_t;

    // Command from the parser to the executor
    typedef enum logic [1:0] {
        CMD_NONE, CMD_LIT, CMD_MATCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t    kind;
        logic [7:0]   lit;
        logic [8:0]   count;     // match byte count, up to 255
        logic [15:0]  offset;
        logic         has_stat;
        logic [2:0]   status;
        logic [LENGTH_BITS-1:0] length;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    // Executor sequencing
    typedef enum logic [1:0] {
        EX_IDLE, EX_COPY, EX_STAT
    } ex_state_t;

endpackage

// ===== rtl/lz4d_parser.sv =====
// Front part: parses tokens, lengths and offsets into commands.
// Depends on lz4d_pkg.
module lz4d_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lz4d_pkg::LENGTH_BITS-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lz4d_pkg::in_item_t            in_data,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output lz4d_pkg::cmd_t                cmd
);
    localparam int LW = lz4d_pkg::LIT_W;

    lz4d_pkg::phase_t phase_reg, phase_next;
    logic [LW-1:0] lit_left_reg, lit_left_next;
    logic [3:0]  nib_reg, nib_next;
    logic [15:0] off_reg, off_next;
    logic [LW-1:0] prod_reg, prod_next;
    logic        failed_reg, failed_next;
    logic [2:0]  fcode_reg, fcode_next;
    logic        over_reg, over_next;
    logic [lz4d_pkg::LENGTH_BITS-1:0] limit_reg;

    logic [7:0] b;
    logic       fire;
    logic [LW:0] lit_sum;
    logic [LW-1:0] lit_sat;
    logic [16:0] full_off;

    assign cfg_ready = 1'b1;
    assign in_ready  = cmd_ready;
    assign fire      = in_valid && in_ready;
    assign cmd_valid = in_valid;
    assign b         = in_data.in_byte;
    assign lit_sum   = {1'b0, lit_left_reg} + (LW+1)'(b);
    assign lit_sat   = lit_sum[LW] ? lz4d_pkg::LIT_SAT : lit_sum[LW-1:0];
    assign full_off  = {1'b0, b, off_reg[7:0]};

    // Decode one byte into state update and command
    always_comb
    begin
        logic [LW+1:0] need;
        logic [8:0]    mcount;
        phase_next    = phase_reg;
        lit_left_next = lit_left_reg;
        nib_next      = nib_reg;
        off_next      = off_reg;
        prod_next     = prod_reg;
        failed_next   = failed_reg;
        fcode_next    = fcode_reg;
        over_next     = over_reg;
        cmd           = '0;
        cmd.kind      = lz4d_pkg::CMD_NONE;
        cmd.lit       = b;
        cmd.offset    = full_off[15:0];
        need          = '0;
        mcount        = '0;
        if (!failed_reg)
        begin
            unique case (phase_reg)
                lz4d_pkg::PH_TOKEN:
                begin
                    if (prod_reg >= LW'(limit_reg))
                    begin
                        failed_next = 1'b1;
                        fcode_next  = lz4d_pkg::ST_OUT_OVER;
                    end
                    else
                    begin
                        nib_next = b[3:0];
                        if (b[7:4] == 4'hf)
                        begin
                            lit_left_next = LW'(15);
                            phase_next    = lz4d_pkg::PH_LIT_EXT;
                        end
                        else if (b[7:4] == 4'h0)
                            phase_next = lz4d_pkg::PH_OFF_LO;
                        else
                        begin
                            lit_left_next = LW'(b[7:4]);
                            over_next = ({2'b0, prod_reg} + (LW+2)'(b[7:4]))
                                        > (LW+2)'(limit_reg);
                            phase_next = lz4d_pkg::PH_LITERALS;
                        end
                    end
                end
                lz4d_pkg::PH_LIT_EXT:
                begin
                    lit_left_next = lit_sat;
                    if (b != 8'hff)
                    begin
                        over_next = ({2'b0, prod_reg} + {2'b0, lit_sat})
                                    > (LW+2)'(limit_reg);
                        phase_next = lz4d_pkg::PH_LITERALS;
                    end
                end
                lz4d_pkg::PH_LITERALS:
                begin
                    if (!over_reg)
                    begin
                        cmd.kind  = lz4d_pkg::CMD_LIT;
                        prod_next = prod_reg + LW'(1);
                    end
                    if (lit_left_reg <= LW'(1))
                    begin
                        lit_left_next = '0;
                        if (over_reg)
                        begin
                            failed_next = 1'b1;
                            fcode_next  = lz4d_pkg::ST_OUT_OVER;
                        end
                        else
                            phase_next = lz4d_pkg::PH_OFF_LO;
                    end
                    else
                        lit_left_next = lit_left_reg - LW'(1);
                end
                lz4d_pkg::PH_OFF_LO:
                begin
                    off_next   = {8'h00, b};
                    phase_next = lz4d_pkg::PH_OFF_HI;
                end
                lz4d_pkg::PH_OFF_HI:
                begin
                    off_next = full_off[15:0];
                    if (full_off == 17'd0 || LW'(full_off) > prod_reg ||
                        full_off > 17'(lz4d_pkg::HISTORY_DEPTH))
                    begin
                        failed_next = 1'b1;
                        fcode_next  = lz4d_pkg::ST_BAD_OFFSET;
                    end
                    else
                    begin
                        mcount = (nib_reg == 4'hf) ? 9'd19 : 9'({nib_reg} + 5'd4);
                        need = {2'b0, prod_reg} + (LW+2)'(mcount);
                        if (need > (LW+2)'(limit_reg))
                            over_next = 1'b1;
                        else
                        begin
                            over_next = 1'b0;
                            cmd.kind  = lz4d_pkg::CMD_MATCH;
                            cmd.count = mcount;
                            prod_next = need[LW-1:0];
                        end
                        if (nib_reg == 4'hf)
                            phase_next = lz4d_pkg::PH_MATCH_EXT;
                        else if (need > (LW+2)'(limit_reg))
                        begin
                            failed_next = 1'b1;
                            fcode_next  = lz4d_pkg::ST_OUT_OVER;
                        end
                        else
                            phase_next = lz4d_pkg::PH_TOKEN;
                    end
                end
                default:
                begin
                    cmd.offset = off_reg;
                    mcount = {1'b0, b};
                    need = {2'b0, prod_reg} + (LW+2)'(mcount);
                    if (over_reg || need > (LW+2)'(limit_reg))
                        over_next = 1'b1;
                    else if (b != 8'h00)
                    begin
                        cmd.kind  = lz4d_pkg::CMD_MATCH;
                        cmd.count = mcount;
                        prod_next = need[LW-1:0];
                    end
                    if (b != 8'hff)
                    begin
                        if (over_next)
                        begin
                            failed_next = 1'b1;
                            fcode_next  = lz4d_pkg::ST_OUT_OVER;
                        end
                        else
                            phase_next = lz4d_pkg::PH_TOKEN;
                    end
                end
            endcase
        end
        // Block end: report and restart
        if (in_data.block_end)
        begin
            cmd.has_stat = 1'b1;
            if (failed_next)
                cmd.status = fcode_next;
            else if (phase_next == lz4d_pkg::PH_TOKEN ||
                     phase_next == lz4d_pkg::PH_OFF_LO)
            begin
                cmd.status = lz4d_pkg::ST_DONE;
                cmd.length = prod_next[lz4d_pkg::LENGTH_BITS-1:0];
            end
            else
                cmd.status = lz4d_pkg::ST_IN_OVER;
            phase_next    = lz4d_pkg::PH_TOKEN;
            lit_left_next = '0;
            nib_next      = '0;
            off_next      = '0;
            prod_next     = '0;
            failed_next   = 1'b0;
            fcode_next    = '0;
            over_next     = 1'b0;
        end
    end

    // Hold parser state between beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= lz4d_pkg::PH_TOKEN;
            lit_left_reg <= '0;
            nib_reg      <= '0;
            off_reg      <= '0;
            prod_reg     <= '0;
            failed_reg   <= 1'b0;
            fcode_reg    <= '0;
            over_reg     <= 1'b0;
            limit_reg    <= lz4d_pkg::LIMIT_RESET;
        end
        else
        begin
            if (cfg_valid)
                limit_reg <= cfg_data;
            if (fire)
            begin
                phase_reg    <= phase_next;
                lit_left_reg <= lit_left_next;
                nib_reg      <= nib_next;
                off_reg      <= off_next;
                prod_reg     <= prod_next;
                failed_reg   <= failed_next;
                fcode_reg    <= fcode_next;
                over_reg     <= over_next;
            end
        end
    end
endmodule

// ===== rtl/lz4d_cmd_fifo.sv =====
// Short queue of commands between parser and executor.
// Depends on lz4d_pkg.
module lz4d_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  lz4d_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output lz4d_pkg::cmd_t rd_data
);
    lz4d_pkg::cmd_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = (cnt_reg != 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 2'd1;
            if (rd)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr) - 3'(rd);
        end
    end
endmodule

// ===== rtl/lz4d_executor.sv =====
// Back part: writes history, copies matches byte by byte, packs words.
// Depends on lz4d_pkg.
module lz4d_executor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  lz4d_pkg::cmd_t     cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output lz4d_pkg::out_item_t out_data
);
    localparam int AW = lz4d_pkg::HIST_AW;

    logic [7:0] hist_mem [lz4d_pkg::HISTORY_DEPTH];
    logic [AW-1:0] wp_reg, wp_next;
    lz4d_pkg::ex_state_t st_reg, st_next;
    logic [8:0]  left_reg, left_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [7:0]  rd_q_reg;
    logic [63:0] word_reg, word_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        ovalid_reg, ovalid_next;
    lz4d_pkg::out_item_t obuf_reg, obuf_next;
    logic        out_free;
    logic        cmd_fire;
    logic        byte_in;
    logic [7:0]  byte_val;
    logic        last_byte;
    logic        beat_last;
    logic        flush;
    logic [63:0] packed_word;
    logic        has_stat_reg, has_stat_next;
    logic [2:0]  stat_reg, stat_next;
    logic [lz4d_pkg::LENGTH_BITS-1:0] len_reg, len_next;

    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;
    assign out_free  = !ovalid_reg || out_ready;

    // Take a command only when idle, output can drain, no read pending
    assign cmd_ready = (st_reg == lz4d_pkg::EX_IDLE) && out_free && !rd_pend_reg;
    assign cmd_fire  = cmd_valid && cmd_ready;

    // Next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            lz4d_pkg::EX_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.kind == lz4d_pkg::CMD_MATCH)
                        st_next = lz4d_pkg::EX_COPY;
                    else if (cmd.has_stat && cmd.kind == lz4d_pkg::CMD_LIT)
                        st_next = lz4d_pkg::EX_STAT;
                end
            end
            lz4d_pkg::EX_COPY:
            begin
                if (!rd_pend_reg && out_free && left_reg == 9'd0)
                    st_next = has_stat_reg ? lz4d_pkg::EX_STAT : lz4d_pkg::EX_IDLE;
            end
            default:
            begin
                if (out_free && !rd_pend_reg)
                    st_next = lz4d_pkg::EX_IDLE;
            end
        endcase
    end

    // One byte entering the packer this cycle
    always_comb
    begin
        byte_in   = 1'b0;
        byte_val  = rd_q_reg;
        last_byte = 1'b0;
        beat_last = 1'b0;
        if (cmd_fire && cmd.kind == lz4d_pkg::CMD_LIT)
        begin
            byte_in   = 1'b1;
            byte_val  = cmd.lit;
            last_byte = 1'b1;
            beat_last = !cmd.has_stat;
        end
        else if (rd_pend_reg)
        begin
            byte_in   = 1'b1;
            last_byte = (left_reg == 9'd0);
            beat_last = (left_reg == 9'd0) && !has_stat_reg;
        end
        flush       = byte_in && (last_byte || cnt_reg == 4'd7);
        packed_word = word_reg | (64'(byte_val) << {cnt_reg[2:0], 3'b000});
    end

    // Copy, packing and output beats
    always_comb
    begin
        wp_next       = wp_reg;
        word_next     = word_reg;
        cnt_next      = cnt_reg;
        ovalid_next   = ovalid_reg && !out_ready;
        obuf_next     = obuf_reg;
        rd_pend_next  = 1'b0;
        rd_addr_next  = rd_addr_reg;
        left_next     = left_reg;
        has_stat_next = has_stat_reg;
        stat_next     = stat_reg;
        len_next      = len_reg;
        if (byte_in)
        begin
            wp_next = wp_reg + AW'(1);
            if (flush)
            begin
                word_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                word_next = packed_word;
                cnt_next  = cnt_reg + 4'd1;
            end
        end
        if (flush)
        begin
            ovalid_next          = 1'b1;
            obuf_next            = '0;
            obuf_next.data_word  = packed_word;
            obuf_next.byte_count = cnt_reg + 4'd1;
            obuf_next.status     = lz4d_pkg::ST_DATA;
            obuf_next.run_last   = beat_last;
        end
        unique case (st_reg)
            lz4d_pkg::EX_IDLE:
            begin
                if (cmd_fire)
                begin
                    has_stat_next = cmd.has_stat;
                    stat_next     = cmd.status;
                    len_next      = cmd.length;
                    if (cmd.kind == lz4d_pkg::CMD_MATCH)
                    begin
                        rd_addr_next = wp_reg - cmd.offset[AW-1:0];
                        left_next    = cmd.count;
                    end
                    else if (cmd.has_stat && cmd.kind != lz4d_pkg::CMD_LIT)
                    begin
                        ovalid_next              = 1'b1;
                        obuf_next                = '0;
                        obuf_next.run_last       = 1'b1;
                        obuf_next.status         = cmd.status;
                        obuf_next.decoded_length = cmd.length;
                    end
                end
            end
            lz4d_pkg::EX_COPY:
            begin
                // Issue the next read once the prior byte is written
                if (!rd_pend_reg && out_free)
                begin
                    if (left_reg != 9'd0)
                    begin
                        rd_pend_next = 1'b1;
                        left_next    = left_reg - 9'd1;
                    end
                end
                else if (rd_pend_reg)
                    rd_addr_next = rd_addr_reg + AW'(1);
            end
            default:
            begin
                if (out_free && !rd_pend_reg)
                begin
                    ovalid_next              = 1'b1;
                    obuf_next                = '0;
                    obuf_next.run_last       = 1'b1;
                    obuf_next.status         = stat_reg;
                    obuf_next.decoded_length = len_reg;
                    has_stat_next            = 1'b0;
                end
            end
        endcase
    end

    // History write of each produced byte, registered history read
    always_ff @(posedge clk)
    begin
        if (byte_in)
            hist_mem[wp_reg] <= byte_val;
        rd_q_reg <= hist_mem[rd_addr_reg];
    end

    // Hold executor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            st_reg       <= lz4d_pkg::EX_IDLE;
            left_reg     <= '0;
            rd_addr_reg  <= '0;
            rd_pend_reg  <= 1'b0;
            cnt_reg      <= '0;
            word_reg     <= '0;
            ovalid_reg   <= 1'b0;
            obuf_reg     <= '0;
            has_stat_reg <= 1'b0;
            stat_reg     <= '0;
            len_reg      <= '0;
        end
        else
        begin
            wp_reg       <= wp_next;
            st_reg       <= st_next;
            left_reg     <= left_next;
            rd_addr_reg  <= rd_addr_next;
            rd_pend_reg  <= rd_pend_next;
            cnt_reg      <= cnt_next;
            word_reg     <= word_next;
            ovalid_reg   <= ovalid_next;
            obuf_reg     <= obuf_next;
            has_stat_reg <= has_stat_next;
            stat_reg     <= stat_next;
            len_reg      <= len_next;
        end
    end
endmodule

// ===== rtl/lz4d_frontend_gate.sv =====
// Drops commands that carry neither data nor status; passes the rest.
// Depends on lz4d_pkg.
module lz4d_frontend_gate (
    input  logic           in_valid,
    output logic           in_ready,
    input  lz4d_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output lz4d_pkg::cmd_t out_cmd
);
    // Drop commands that carry neither data nor status
    logic empty;
    assign empty     = (in_cmd.kind == lz4d_pkg::CMD_NONE) && !in_cmd.has_stat;
    assign out_valid = in_valid && !empty;
    assign in_ready  = empty ? 1'b1 : out_ready;
    assign out_cmd   = in_cmd;
endmodule

// ===== rtl/lz4_block_decoder_core.sv =====
// Top level of the LZ4 block decoder: parser, command queue, executor.
// Depends on lz4d_pkg and the lz4d_* modules.
//
//  channel | direction | payload
//  in      | input     | in_item_t (in_byte, block_end)
//  cfg     | input     | output_limit, 24 bits
//  out     | output    | out_item_t (data_word, byte_count, run_last, status,
//          |           |             decoded_length)
//
// The parser takes one byte a cycle while the queue has room. The executor
// passes a literal or a status beat straight through; a match is started,
// copied byte by byte (each history read waits for the previous byte's
// write) and then finished, so the executor sets the pace. Output stalls
// hold the executor, which then fills the queue and stalls the input.
// Reset clears control only; history is not cleared.
module lz4_block_decoder_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [lz4d_pkg::LENGTH_BITS-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lz4d_pkg::in_item_t     in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lz4d_pkg::out_item_t    out_data
);
    logic p_valid, p_ready, g_valid, g_ready, q_valid, q_ready;
    lz4d_pkg::cmd_t p_cmd, g_cmd, q_cmd;

    lz4d_parser u_parser (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .cmd_valid(p_valid), .cmd_ready(p_ready), .cmd(p_cmd)
    );

    lz4d_frontend_gate u_gate (
        .in_valid(p_valid), .in_ready(p_ready), .in_cmd(p_cmd),
        .out_valid(g_valid), .out_ready(g_ready), .out_cmd(g_cmd)
    );

    lz4d_cmd_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(g_valid), .wr_ready(g_ready), .wr_data(g_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    lz4d_executor u_exec (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );
endmodule

// ===== tb/lz4_checker.sv =====
// Checker for the LZ4 block decoder: watches the cfg, in and out channels,
// predicts each output beat and compares it field by field. Depends on lz4d_pkg.
`timescale 1ns / 1ps

module lz4_checker
    import lz4d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [LENGTH_BITS-1:0] cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  in_item_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  out_item_t              out_data,
    output int                     fail_count,
    output int                     pending
);

    // Decoder state as predicted
    logic [7:0]   hist [HISTORY_DEPTH];
    longint       limit;
    phase_t       ph;
    longint       lits_left;
    logic [3:0]   m_nibble;
    longint       m_offset;
    longint       produced;
    bit           failed;
    status_t      fail_code;
    bit           run_over;

    out_item_t    expected_beats [$];
    out_item_t    step_beats [$];

    localparam longint LIT_MAX = (longint'(1) << LIT_W) - 1;

    assign pending = expected_beats.size();

    task automatic clear_block();
        ph        = PH_TOKEN;
        lits_left = 0;
        m_nibble  = '0;
        m_offset  = 0;
        produced  = 0;
        failed    = 0;
        fail_code = ST_DATA;
        run_over  = 0;
    endtask

    task automatic add_beat(input logic [63:0] w, input int cnt, input status_t st,
                            input longint len);
        out_item_t r;
        r.data_word      = w;
        r.byte_count     = 4'(cnt);
        r.run_last       = 1'b0;
        r.status         = st;
        r.decoded_length = LENGTH_BITS'(len);
        step_beats.push_back(r);
    endtask

    // Copy match bytes from history in words of up to eight
    task automatic copy_match(input longint n);
        logic [63:0] w;
        int          cnt;
        logic [7:0]  b;
        if (run_over || produced + n > limit) begin
            run_over = 1;
            return;
        end
        while (n > 0) begin
            w   = '0;
            cnt = 0;
            while (n > 0 && cnt < 8) begin
                b = hist[16'(produced - m_offset)];
                hist[16'(produced)] = b;
                produced++;
                w[8*cnt +: 8] = b;
                cnt++;
                n--;
            end
            add_beat(w, cnt, ST_DATA, 0);
        end
    endtask

    task automatic start_literals(input longint n);
        lits_left = n;
        run_over  = (produced + n > limit);
        ph        = PH_LITERALS;
    endtask

    task automatic fail_with(input status_t code);
        failed    = 1;
        fail_code = code;
    endtask

    // Advance the parser by one compressed byte
    task automatic decode_byte(input logic [7:0] b, input logic e);
        out_item_t r;
        step_beats.delete();
        if (!failed) begin
            case (ph)
                PH_TOKEN: begin
                    if (produced >= limit) begin
                        fail_with(ST_OUT_OVER);
                    end
                    else begin
                        m_nibble = b[3:0];
                        if (b[7:4] == 4'hF) begin
                            lits_left = 15;
                            ph        = PH_LIT_EXT;
                        end
                        else if (b[7:4] == 4'h0) begin
                            ph = PH_OFF_LO;
                        end
                        else begin
                            start_literals(b[7:4]);
                        end
                    end
                end
                PH_LIT_EXT: begin
                    lits_left += b;
                    if (lits_left > LIT_MAX)
                        lits_left = LIT_MAX;
                    if (b != 8'hFF)
                        start_literals(lits_left);
                end
                PH_LITERALS: begin
                    if (!run_over) begin
                        hist[16'(produced)] = b;
                        produced++;
                        add_beat(64'(b), 1, ST_DATA, 0);
                    end
                    if (lits_left > 0)
                        lits_left--;
                    if (lits_left == 0) begin
                        if (run_over)
                            fail_with(ST_OUT_OVER);
                        else
                            ph = PH_OFF_LO;
                    end
                end
                PH_OFF_LO: begin
                    m_offset = b;
                    ph       = PH_OFF_HI;
                end
                PH_OFF_HI: begin
                    m_offset = m_offset | (longint'(b) << 8);
                    if (m_offset == 0 || m_offset > produced || m_offset > HISTORY_DEPTH) begin
                        fail_with(ST_BAD_OFFSET);
                    end
                    else begin
                        run_over = 0;
                        if (m_nibble == 4'hF) begin
                            copy_match(19);
                            ph = PH_MATCH_EXT;
                        end
                        else begin
                            copy_match(longint'(m_nibble) + 4);
                            if (run_over)
                                fail_with(ST_OUT_OVER);
                            else
                                ph = PH_TOKEN;
                        end
                    end
                end
                default: begin
                    copy_match(b);
                    if (b != 8'hFF) begin
                        if (run_over)
                            fail_with(ST_OUT_OVER);
                        else
                            ph = PH_TOKEN;
                    end
                end
            endcase
        end
        if (e) begin
            if (failed)
                add_beat('0, 0, fail_code, 0);
            else if (ph == PH_TOKEN || ph == PH_OFF_LO)
                add_beat('0, 0, ST_DONE, produced);
            else
                add_beat('0, 0, ST_IN_OVER, 0);
            clear_block();
        end
        // Mark the last beat of this byte, then queue them all
        if (step_beats.size() > 0) begin
            r = step_beats[step_beats.size()-1];
            r.run_last = 1'b1;
            step_beats[step_beats.size()-1] = r;
        end
        foreach (step_beats[i])
            expected_beats.push_back(step_beats[i]);
    endtask

    task automatic check_beat(input out_item_t got);
        out_item_t want;
        if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, got);
            fail_count++;
            return;
        end
        want = expected_beats.pop_front();
        if (got.data_word !== want.data_word) begin
            $display("%0t: data_word expected %h actual %h", $time, want.data_word,
                     got.data_word);
            fail_count++;
        end
        if (got.byte_count !== want.byte_count) begin
            $display("%0t: byte_count expected %0d actual %0d", $time, want.byte_count,
                     got.byte_count);
            fail_count++;
        end
        if (got.run_last !== want.run_last) begin
            $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                     got.run_last);
            fail_count++;
        end
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     got.status);
            fail_count++;
        end
        if (got.decoded_length !== want.decoded_length) begin
            $display("%0t: decoded_length expected %0d actual %0d", $time,
                     want.decoded_length, got.decoded_length);
            fail_count++;
        end
    endtask

    // Sample every channel at the rising edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limit = longint'(LIMIT_RESET);
            clear_block();
            expected_beats.delete();
        end
        else begin
            if (cfg_valid && cfg_ready)
                limit = longint'(cfg_data);
            if (in_valid && in_ready)
                decode_byte(in_data.in_byte, in_data.block_end);
            if (out_valid && out_ready)
                check_beat(out_data);
        end
    end

    initial fail_count = 0;

endmodule

// ===== tb/tb.sv =====
// Top of the LZ4 block decoder testbench: clock, reset, stimulus and verdict.
// Depends on lz4d_pkg, lz4_block_decoder_core and lz4_checker.
`timescale 1ns / 1ps

module tb;
    import lz4d_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [LENGTH_BITS-1:0] cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    int                     fail_count;
    int                     pending;

    logic [7:0] blk [$];
    int         burst_left;
    bit         full_rate;
    int         hold_reqs;
    int         holds_done;
    int         hold_cnt;
    int         rx_period;
    int         rx_cnt;
    int         random_bytes;

    lz4_block_decoder_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    lz4_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Receiver: long hold-offs on request, otherwise a stall pattern
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            holds_done <= 0;
            hold_cnt   <= 0;
            rx_period  <= 1;
            rx_cnt     <= 0;
        end
        else if (hold_cnt > 0) begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end
        else if (holds_done != hold_reqs) begin
            out_ready  <= 1'b0;
            hold_cnt   <= 600;
            holds_done <= holds_done + 1;
        end
        else begin
            rx_cnt    <= rx_cnt + 1;
            out_ready <= (rx_period == 1) || ((rx_cnt % rx_period) != 0);
            if (rx_cnt % 64 == 63)
                rx_period <= $urandom_range(1, 5);
        end
    end

    // Offer one byte, in bursts with random gaps; starts and ends at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic e);
        if (burst_left == 0) begin
            if (!full_rate) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, block_end: e};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_block();
        foreach (blk[i])
            send_byte(blk[i], i == blk.size() - 1);
    endtask

    // Write the output limit once the decoder has drained
    task automatic set_limit(input logic [LENGTH_BITS-1:0] v);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (64) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_len(input int n);
        while (n >= 255) begin
            blk.push_back(8'hFF);
            n -= 255;
        end
        blk.push_back(8'(n));
    endtask

    // Build a well-formed block of random sequences, with an optional bad offset
    task automatic build_block(input int nseq, input bit bad_off);
        int lit;
        int ml;
        int gl;
        int off;
        blk.delete();
        gl = 0;
        for (int s = 0; s < nseq; s++) begin
            lit = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40)
                                              : $urandom_range(0, 14);
            if (s != nseq - 1 && gl + lit == 0)
                lit = 1;
            ml = ($urandom_range(0, 3) == 0) ? $urandom_range(19, 60) : $urandom_range(4, 18);
            blk.push_back({(lit >= 15) ? 4'hF : 4'(lit), (ml >= 19) ? 4'hF : 4'(ml - 4)});
            if (lit >= 15)
                push_len(lit - 15);
            repeat (lit) blk.push_back(8'($urandom()));
            gl += lit;
            if (s == nseq - 1)
                break;
            off = $urandom_range(0, 1) ? $urandom_range(1, (gl < 8) ? gl : 8)
                                       : $urandom_range(1, gl);
            if (bad_off)
                off = $urandom_range(0, 1) ? 0 : gl + $urandom_range(1, 300);
            blk.push_back(off[7:0]);
            blk.push_back(off[15:8]);
            if (ml >= 19)
                push_len(ml - 19);
            gl += ml;
        end
    endtask

    initial begin
        int kind;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        hold_reqs  = 0;
        burst_left = 0;
        full_rate  = 0;
        random_bytes = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty block, then literals only
        blk = '{8'h00};
        send_block();
        blk = '{8'h30, 8'h00, 8'hFF, 8'hA5};
        send_block();
        // Overlapping copy at offset 1, then a closing empty token
        blk = '{8'h40, 8'h11, 8'h22, 8'h33, 8'h44, 8'h01, 8'h00, 8'h00};
        send_block();
        // Chained literal length, block ends inside the literals
        blk = '{8'hF0, 8'hFF, 8'h03, 8'h11, 8'h22};
        send_block();
        // Long match with extension bytes
        blk = '{8'h2F, 8'h5A, 8'hC3, 8'h02, 8'h00, 8'hFF, 8'h0A, 8'h00};
        send_block();
        // Zero offset, offset past the decoded bytes
        blk = '{8'h10, 8'h77, 8'h00, 8'h00};
        send_block();
        blk = '{8'h10, 8'h77, 8'h02, 8'h00, 8'h10};
        send_block();
        // Block ends inside a length extension, the literals, the offset
        blk = '{8'hF0, 8'hFF};
        send_block();
        blk = '{8'h30, 8'h01, 8'h02};
        send_block();
        blk = '{8'h10, 8'h01, 8'h01};
        send_block();

        // Limit overflows: a literal run, a match, a token at the limit
        set_limit(24'd3);
        blk = '{8'h50, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h00};
        send_block();
        blk = '{8'h30, 8'h01, 8'h02, 8'h03, 8'h01, 8'h00, 8'h00};
        send_block();
        blk = '{8'h20, 8'h01, 8'h02, 8'h01, 8'h00, 8'h00};
        send_block();
        set_limit(24'd0);
        blk = '{8'h00};
        send_block();
        set_limit(24'hFFFFFF);

        // Hold the receiver off while literals and a long match keep arriving
        hold_reqs++;
        full_rate = 1;
        blk = '{8'hEF};
        repeat (14) blk.push_back(8'($urandom()));
        blk.push_back(8'h01);
        blk.push_back(8'h00);
        blk.push_back(8'h40);
        blk.push_back(8'h00);
        send_block();
        full_rate = 0;

        // Random blocks under several limits
        for (int round = 0; random_bytes < 165; round++) begin
            if (round % 2 == 0) begin
                case ($urandom_range(0, 3))
                    0: set_limit(LIMIT_RESET);
                    1: set_limit(24'hFFFFFF);
                    2: set_limit(24'($urandom_range(20, 200)));
                    default: set_limit(24'($urandom_range(0, 5)));
                endcase
            end
            kind = $urandom_range(0, 9);
            build_block($urandom_range(1, 5), kind == 9);
            if (kind == 7 && blk.size() > 1)
                blk = blk[0:$urandom_range(0, blk.size() - 2)];
            if (kind == 8)
                blk[$urandom_range(0, blk.size() - 1)] = 8'($urandom());
            random_bytes += blk.size();
            send_block();
            if ($urandom_range(0, 5) == 0) begin
                in_valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
        end

        // Drain
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Bound the run
    initial begin
        #5ms;
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== lz4_block_decoder_core.f =====
rtl/lz4d_pkg.sv
rtl/lz4d_parser.sv
rtl/lz4d_cmd_fifo.sv
rtl/lz4d_executor.sv
rtl/lz4d_frontend_gate.sv
rtl/lz4_block_decoder_core.sv
tb/lz4_checker.sv
tb/tb.sv
